@@ rtl/u2a_pkg.sv @@
// Package with the widths, constants and helpers of the unsigned-to-ASCII converter.
package u2a_pkg;
    localparam int ValueBits    = 32;
    localparam int MaxDigits    = 10;
    localparam int CountBits    = $clog2(MaxDigits + 1);
    localparam int IdxBits      = $clog2(MaxDigits);
    localparam int BcdBits      = 4 * MaxDigits;
    localparam int StageShifts  = 4;
    localparam int DabbleStages = ValueBits / StageShifts;

    localparam logic [6:0] CharZero   = 7'h30;
    localparam logic [6:0] CharLowerA = 7'h61;
    localparam logic [3:0] DecRadix   = 4'd10;

    typedef enum logic {
        t_RADIX_DEC = 1'b0,
        t_RADIX_HEX = 1'b1
    } t_radix;

    // Map one digit value to its ASCII character.
    function automatic logic [6:0] digit_to_char(input logic [3:0] d);
        logic [6:0] c;
        if (d < DecRadix) begin
            c = CharZero + {3'b000, d};
        end else begin
            c = CharLowerA + {3'b000, 4'(d - DecRadix)};
        end
        return c;
    endfunction
endpackage

@@ rtl/u2a_divider.sv @@
// One pipeline stage of the binary-to-decimal conversion by shift and add-three.
module u2a_divider
    import u2a_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [BcdBits-1:0]   i_bcd,
    input  logic [ValueBits-1:0] i_bin,
    input  logic                 i_hex,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [BcdBits-1:0]   o_bcd,
    output logic [ValueBits-1:0] o_bin,
    output logic                 o_hex
);
    logic                 r_valid;
    logic [BcdBits-1:0]   r_bcd, n_bcd;
    logic [ValueBits-1:0] r_bin, n_bin;
    logic                 r_hex;
    logic                 load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    // Hexadecimal items already hold their digits and pass through unchanged.
    always_comb begin
        n_bcd = i_bcd;
        n_bin = i_bin;
        if (!i_hex) begin
            for (int s = 0; s < StageShifts; s++) begin
                for (int d = 0; d < MaxDigits; d++) begin
                    if (n_bcd[4*d +: 4] >= 4'd5) begin
                        n_bcd[4*d +: 4] = n_bcd[4*d +: 4] + 4'd3;
                    end
                end
                n_bcd = {n_bcd[BcdBits-2:0], n_bin[ValueBits-1]};
                n_bin = {n_bin[ValueBits-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (load) begin
            r_bcd <= n_bcd;
            r_bin <= n_bin;
            r_hex <= i_hex;
        end
    end

    assign o_valid = r_valid;
    assign o_bcd   = r_bcd;
    assign o_bin   = r_bin;
    assign o_hex   = r_hex;
endmodule

@@ rtl/unsigned_to_ascii_digits.sv @@
// Top level of the unsigned-to-ASCII converter: conversion pipeline, digit store and output.
//
// Channel | Direction | Handshake            | Payload
// input   | in        | i_valid / o_ready    | i_action, i_value
// output  | out       | o_valid / i_ready    | o_digit_char, o_last
//
// A decimal value is turned into packed decimal digits by shift and add-three, four bits
// per stage over eight register stages; a hexadecimal value simply rides through them.
// The first character is valid once the item has passed the stages, the digit store and
// the output register, and the following ones come one per cycle while the output does not
// stall; the store takes the next item in the cycle after the last character is loaded.
// Reset is synchronous and active low; it clears every stage valid, the store and the
// output valid. A stall on the output holds the current character, the stages fill up
// one by one and o_ready falls once all of them hold an item; nothing is dropped.
module unsigned_to_ascii_digits
    import u2a_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_action,
    input  logic [ValueBits-1:0] i_value,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [6:0]           o_digit_char,
    output logic                 o_last
);
    // Handshake and data between the stages; index 0 is the input side.
    logic                 st_valid [DabbleStages+1];
    logic                 st_ready [DabbleStages+1];
    logic [BcdBits-1:0]   st_bcd   [DabbleStages+1];
    logic [ValueBits-1:0] st_bin   [DabbleStages+1];
    logic                 st_hex   [DabbleStages+1];
    logic                 in_hex;
    logic [CountBits-1:0] top_count;
    logic [IdxBits-1:0]   rd_idx;
    logic                 take;
    logic                 r_busy, n_busy;
    logic [BcdBits-1:0]   r_digits, n_digits;
    logic [CountBits-1:0] r_count, n_count;
    logic                 r_oval, n_oval;
    logic [6:0]           r_ochar, n_ochar;
    logic                 r_olast, n_olast;

    // A hexadecimal value is already its own digit list, one digit per nibble, so it
    // enters with its digits in place and nothing left to shift in.
    assign in_hex      = (t_radix'(i_action) == t_RADIX_HEX);
    assign st_valid[0] = i_valid;
    assign st_bcd[0]   = in_hex ? BcdBits'(i_value) : '0;
    assign st_bin[0]   = in_hex ? '0 : i_value;
    assign st_hex[0]   = in_hex;
    assign o_ready     = st_ready[0];

    for (genvar k = 0; k < DabbleStages; k++) begin : g_stage
        u2a_divider u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[k]),
            .o_ready (st_ready[k]),
            .i_bcd   (st_bcd[k]),
            .i_bin   (st_bin[k]),
            .i_hex   (st_hex[k]),
            .o_valid (st_valid[k+1]),
            .i_ready (st_ready[k+1]),
            .o_bcd   (st_bcd[k+1]),
            .o_bin   (st_bin[k+1]),
            .o_hex   (st_hex[k+1])
        );
    end

    // The store takes a new item only once the previous item's last character has been loaded.
    assign st_ready[DabbleStages] = !r_busy;
    assign take                   = st_valid[DabbleStages] && !r_busy;
    assign rd_idx                 = IdxBits'(r_count - 1'b1);

    // Number of digits to send: up to the most significant non-zero digit, and at
    // least one so that a zero value still gives a single '0'.
    always_comb begin
        top_count = CountBits'(1);
        for (int d = 1; d < MaxDigits; d++) begin
            if (st_bcd[DabbleStages][4*d +: 4] != 4'd0) begin
                top_count = CountBits'(d + 1);
            end
        end
    end

    // Characters leave most significant first; r_count is the number still to send.
    always_comb begin
        n_busy   = r_busy;
        n_digits = r_digits;
        n_count  = r_count;
        n_oval   = r_oval;
        n_ochar  = r_ochar;
        n_olast  = r_olast;
        if (r_oval && i_ready) begin
            n_oval = 1'b0;
        end
        if (take) begin
            n_busy   = 1'b1;
            n_digits = st_bcd[DabbleStages];
            n_count  = top_count;
        end else if (r_busy && (!r_oval || i_ready)) begin
            n_oval  = 1'b1;
            n_ochar = digit_to_char(r_digits[{rd_idx, 2'b00} +: 4]);
            n_olast = (r_count == CountBits'(1));
            n_count = r_count - 1'b1;
            if (r_count == CountBits'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_count <= n_count;
            r_oval  <= n_oval;
        end
        r_digits <= n_digits;
        r_ochar  <= n_ochar;
        r_olast  <= n_olast;
    end

    assign o_valid      = r_oval;
    assign o_digit_char = r_ochar;
    assign o_last       = r_olast;
endmodule
